// ===== sv/tsadc_pkg.sv =====
package tsadc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_STEPS   = 24;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [CFG_INDEX_W-1:0] REG_ADC_X_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADC_Y_LOW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_X_LOW = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_Y_LOW = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ADC_X_HIGH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ADC_Y_HIGH   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_X_HIGH = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_Y_HIGH = 3'd7;

    localparam logic [2:0]  CH_Y      = 3'd1;
    localparam logic [2:0]  CH_X      = 3'd5;
    localparam logic [15:0] IDLE_LOAD = 16'h7FF8;
    localparam logic [11:0] ADC_MAX   = 12'hFFF;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } tsadc_state_t;

    typedef struct packed
    {
        logic accept;
        logic mul;
        logic div_step;
        logic finish;
    } tsadc_cmd_t;

    typedef struct packed
    {
        logic calc_needed;
        logic div_last;
    } tsadc_stat_t;

endpackage

// ===== sv/tsadc_req_if.sv =====
interface tsadc_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] spi_byte_in;
    logic       pen_down;
    logic [7:0] touch_x;
    logic [7:0] touch_y;

    modport source
    (
        output valid,
        output spi_byte_in,
        output pen_down,
        output touch_x,
        output touch_y,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  spi_byte_in,
        input  pen_down,
        input  touch_x,
        input  touch_y,
        output ready
    );
endinterface

// ===== sv/tsadc_rsp_if.sv =====
interface tsadc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] spi_byte_out;

    modport source
    (
        output valid,
        output spi_byte_out,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  spi_byte_out,
        output ready
    );
endinterface

// ===== sv/tsadc_ctrl.sv =====
module tsadc_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  tsadc_pkg::tsadc_stat_t stat,
    output tsadc_pkg::tsadc_cmd_t  cmd
);
    import tsadc_pkg::*;

    tsadc_state_t state_reg;
    tsadc_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = !out_valid_reg || out_ready;
                cmd.accept = in_valid && in_ready;
                if (cmd.accept && stat.calc_needed)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/tsadc_dpath.sv =====
module tsadc_dpath
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  tsadc_pkg::tsadc_cmd_t                   cmd,
    output tsadc_pkg::tsadc_stat_t                  stat,
    input  logic [7:0]                              spi_byte_in,
    input  logic                                    pen_down,
    input  logic [7:0]                              touch_x,
    input  logic [7:0]                              touch_y,
    input  logic                                    cfg_we,
    input  logic [tsadc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [tsadc_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic [7:0]                              spi_byte_out
);
    import tsadc_pkg::*;

    logic [15:0] adc_x_low_reg;
    logic [15:0] adc_y_low_reg;
    logic [7:0]  scr_x_low_reg;
    logic [7:0]  scr_y_low_reg;
    logic [15:0] adc_x_high_reg;
    logic [15:0] adc_y_high_reg;
    logic [7:0]  scr_x_high_reg;
    logic [7:0]  scr_y_high_reg;

    logic [15:0] shift_reg;
    logic [15:0] shift_next;

    logic [7:0]  byte_out_reg;
    logic        sel_y_reg;
    logic [7:0]  scr_reg;
    logic [23:0] quot_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  den_reg;
    logic        neg_reg;
    logic        den_zero_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [2:0]  channel;
    logic        start;
    logic [7:0]  scr_lo;
    logic [7:0]  scr_hi;
    logic [15:0] adc_lo;
    logic [15:0] adc_hi;
    logic [9:0]  a_diff;
    logic [9:0]  a_abs;
    logic [17:0] b_diff;
    logic [17:0] b_abs;
    logic [8:0]  d_diff;
    logic [8:0]  d_abs;
    logic [24:0] product;
    logic [8:0]  rem_shift;
    logic        rem_ge;
    logic [24:0] q_ext;
    logic [24:0] q_signed;
    logic [25:0] mapped;
    logic [11:0] sat;

    assign channel = spi_byte_in[6:4];
    assign start   = spi_byte_in[7];

    assign stat.calc_needed = start && pen_down && (channel == CH_Y || channel == CH_X);
    assign stat.div_last    = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    assign scr_lo = sel_y_reg ? scr_y_low_reg  : scr_x_low_reg;
    assign scr_hi = sel_y_reg ? scr_y_high_reg : scr_x_high_reg;
    assign adc_lo = sel_y_reg ? adc_y_low_reg  : adc_x_low_reg;
    assign adc_hi = sel_y_reg ? adc_y_high_reg : adc_x_high_reg;

    always_comb
    begin
        a_diff  = {2'b00, scr_reg} - {2'b00, scr_lo} + 10'd1;
        a_abs   = a_diff[9] ? (~a_diff + 10'd1) : a_diff;
        b_diff  = {2'b00, adc_hi} - {2'b00, adc_lo};
        b_abs   = b_diff[17] ? (~b_diff + 18'd1) : b_diff;
        d_diff  = {1'b0, scr_hi} - {1'b0, scr_lo};
        d_abs   = d_diff[8] ? (~d_diff + 9'd1) : d_diff;
        product = a_abs[8:0] * b_abs[15:0];

        rem_shift = {rem_reg[7:0], quot_reg[23]};
        rem_ge    = (rem_shift >= {1'b0, den_reg});

        q_ext    = {1'b0, quot_reg};
        q_signed = neg_reg ? (~q_ext + 25'd1) : q_ext;
        if (den_zero_reg)
        begin
            mapped = {10'd0, adc_lo};
        end
        else
        begin
            mapped = {q_signed[24], q_signed} + {10'd0, adc_lo};
        end

        if (mapped[25])
        begin
            sat = 12'd0;
        end
        else if (mapped[24:12] != 13'd0)
        begin
            sat = ADC_MAX;
        end
        else
        begin
            sat = mapped[11:0];
        end

        shift_next = shift_reg;
        if (cmd.accept)
        begin
            shift_next = {shift_reg[7:0], 8'h00};
            if (start && !stat.calc_needed)
            begin
                shift_next = (channel == CH_X) ? 16'h0000 : IDLE_LOAD;
            end
        end
        else if (cmd.finish)
        begin
            shift_next = {1'b0, sat, 3'b000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= 16'h0000;
            adc_x_low_reg  <= 16'd0;
            adc_y_low_reg  <= 16'd0;
            scr_x_low_reg  <= 8'd0;
            scr_y_low_reg  <= 8'd0;
            adc_x_high_reg <= 16'd4095;
            adc_y_high_reg <= 16'd4095;
            scr_x_high_reg <= 8'd255;
            scr_y_high_reg <= 8'd191;
        end
        else
        begin
            shift_reg <= shift_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ADC_X_LOW:     adc_x_low_reg  <= cfg_data;
                    REG_ADC_Y_LOW:     adc_y_low_reg  <= cfg_data;
                    REG_SCREEN_X_LOW:  scr_x_low_reg  <= cfg_data[7:0];
                    REG_SCREEN_Y_LOW:  scr_y_low_reg  <= cfg_data[7:0];
                    REG_ADC_X_HIGH:    adc_x_high_reg <= cfg_data;
                    REG_ADC_Y_HIGH:    adc_y_high_reg <= cfg_data;
                    REG_SCREEN_X_HIGH: scr_x_high_reg <= cfg_data[7:0];
                    REG_SCREEN_Y_HIGH: scr_y_high_reg <= cfg_data[7:0];
                    default:           adc_x_low_reg  <= adc_x_low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_out_reg <= shift_reg[15:8];
            sel_y_reg    <= (channel == CH_Y);
            scr_reg      <= (channel == CH_Y) ? touch_y : touch_x;
        end
        if (cmd.mul)
        begin
            quot_reg     <= product[23:0];
            rem_reg      <= 9'd0;
            den_reg      <= d_abs[7:0];
            neg_reg      <= a_diff[9] ^ b_diff[17] ^ d_diff[8];
            den_zero_reg <= (d_diff == 9'd0);
            cnt_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            quot_reg <= {quot_reg[22:0], rem_ge};
            cnt_reg  <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign spi_byte_out = byte_out_reg;

endmodule

// ===== sv/touch_screen_adc_spi_responder.sv =====
// Each request is answered in the cycle after it is accepted, from an output register.
// A request without a pen-down X or Y conversion leaves the controller idle, so these stream
// back to back while the receiver takes each reply. A conversion request holds off the input
// after it is accepted for one multiply step, the one-bit-per-cycle restoring divider and a
// final step that offsets, saturates and loads the shift register.
// Reset clears the shift register and the handshake state and restores the calibration defaults.
module touch_screen_adc_spi_responder
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    tsadc_req_if.sink                             req,
    tsadc_rsp_if.source                           rsp,
    input  logic                                  cfg_we,
    input  logic [tsadc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tsadc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tsadc_pkg::*;

    tsadc_cmd_t  cmd;
    tsadc_stat_t stat;

    tsadc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tsadc_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .spi_byte_in  (req.spi_byte_in),
        .pen_down     (req.pen_down),
        .touch_x      (req.touch_x),
        .touch_y      (req.touch_y),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .spi_byte_out (rsp.spi_byte_out)
    );

endmodule

// ===== tb/sv/touch_screen_reply_checker.sv =====
`timescale 1ns / 1ps

module touch_screen_reply_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    tsadc_req_if                              req,
    tsadc_rsp_if                              rsp,
    input  logic                              cfg_we,
    input  logic [tsadc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsadc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                mismatches,
    output int                                pending
);
    import tsadc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [15:0] cal [8];
    logic [15:0] conversion_word;
    logic [15:0] next_word;
    logic [11:0] axis_x;
    logic [11:0] axis_y;
    logic [7:0]  wanted_reply;
    logic [7:0]  pending_replies [$];

    // Two-point linear calibration from screen pixel to ADC code, clamped to twelve bits.
    function automatic logic [11:0] calibrate_axis
    (
        input logic [7:0]  pixel,
        input logic [7:0]  pixel_low,
        input logic [7:0]  pixel_high,
        input logic [15:0] code_low,
        input logic [15:0] code_high
    );
        longint p;
        longint p_lo;
        longint p_hi;
        longint c_lo;
        longint c_hi;
        longint quotient;
        longint code;
        p = pixel;
        p_lo = pixel_low;
        p_hi = pixel_high;
        c_lo = code_low;
        c_hi = code_high;
        if (p_hi != p_lo)
        begin
            quotient = ((p - p_lo + 1) * (c_hi - c_lo)) / (p_hi - p_lo);
        end
        else
        begin
            quotient = 0;
        end
        code = quotient + c_lo;
        if (code < 0)
        begin
            code = 0;
        end
        else if (code > longint'(ADC_MAX))
        begin
            code = longint'(ADC_MAX);
        end
        return code[11:0];
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] wanted, input logic [7:0] seen);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected 0x%02h, got 0x%02h", $realtime, what, wanted, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal[REG_ADC_X_LOW]     = 16'd0;
            cal[REG_ADC_Y_LOW]     = 16'd0;
            cal[REG_SCREEN_X_LOW]  = 16'd0;
            cal[REG_SCREEN_Y_LOW]  = 16'd0;
            cal[REG_ADC_X_HIGH]    = 16'd4095;
            cal[REG_ADC_Y_HIGH]    = 16'd4095;
            cal[REG_SCREEN_X_HIGH] = 16'd255;
            cal[REG_SCREEN_Y_HIGH] = 16'd191;
            conversion_word = 16'h0000;
            pending_replies.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_X_LOW, REG_SCREEN_Y_LOW, REG_SCREEN_X_HIGH, REG_SCREEN_Y_HIGH:
                        cal[cfg_index] = {8'h00, cfg_data[7:0]};
                    default:
                        cal[cfg_index] = cfg_data;
                endcase
            end

            if (rsp.valid && rsp.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    note_mismatch("reply with no request outstanding", 8'h00, rsp.spi_byte_out);
                end
                else
                begin
                    wanted_reply = pending_replies.pop_front();
                    if (rsp.spi_byte_out !== wanted_reply)
                    begin
                        note_mismatch("spi_byte_out", wanted_reply, rsp.spi_byte_out);
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                pending_replies.push_back(conversion_word[15:8]);
                next_word = {conversion_word[7:0], 8'h00};
                if (req.spi_byte_in[7])
                begin
                    axis_x = 12'd0;
                    axis_y = ADC_MAX;
                    if (req.pen_down)
                    begin
                        axis_x = calibrate_axis(req.touch_x, cal[REG_SCREEN_X_LOW][7:0],
                                                cal[REG_SCREEN_X_HIGH][7:0],
                                                cal[REG_ADC_X_LOW], cal[REG_ADC_X_HIGH]);
                        axis_y = calibrate_axis(req.touch_y, cal[REG_SCREEN_Y_LOW][7:0],
                                                cal[REG_SCREEN_Y_HIGH][7:0],
                                                cal[REG_ADC_Y_LOW], cal[REG_ADC_Y_HIGH]);
                    end
                    case (req.spi_byte_in[6:4])
                        CH_Y:    next_word = {1'b0, axis_y, 3'b000};
                        CH_X:    next_word = {1'b0, axis_x, 3'b000};
                        default: next_word = IDLE_LOAD;
                    endcase
                end
                conversion_word = next_word;
            end
        end
        pending = pending_replies.size();
    end

endmodule

// ===== tb/sv/touch_screen_adc_spi_responder_test.sv =====
`timescale 1ns / 1ps

module touch_screen_adc_spi_responder_test;

    import tsadc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 155;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int requests_sent;
    int replies_seen = 0;
    int cycles = 0;
    int mismatches;
    int pending;

    tsadc_req_if req ();
    tsadc_rsp_if rsp ();

    touch_screen_adc_spi_responder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    touch_screen_reply_checker reply_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver either stalls at random or, when a hold-off is asked for, refuses
    // every reply for a long stretch so that the block backs up onto its request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready   <= 1'b0;
            hold_served <= 0;
            hold_left   <= 0;
        end
        else if (hold_left > 0)
        begin
            rsp.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            rsp.ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rsp.valid && rsp.ready)
        begin
            replies_seen <= replies_seen + 1;
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request
    (
        input logic [7:0] spi_byte,
        input logic       pen,
        input logic [7:0] x,
        input logic [7:0] y
    );
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.spi_byte_in <= spi_byte;
        req.pen_down    <= pen;
        req.touch_x     <= x;
        req.touch_y     <= y;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    task automatic drain_replies;
        req.valid <= 1'b0;
        while (replies_seen != requests_sent)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Screen registers are eight bits wide; random upper bits check that they are dropped.
    task automatic load_calibration
    (
        input logic [15:0] adc_x_low,
        input logic [15:0] adc_y_low,
        input logic [7:0]  screen_x_low,
        input logic [7:0]  screen_y_low,
        input logic [15:0] adc_x_high,
        input logic [15:0] adc_y_high,
        input logic [7:0]  screen_x_high,
        input logic [7:0]  screen_y_high
    );
        write_reg(REG_ADC_X_LOW, adc_x_low);
        write_reg(REG_ADC_Y_LOW, adc_y_low);
        write_reg(REG_SCREEN_X_LOW, {8'($urandom_range(255)), screen_x_low});
        write_reg(REG_SCREEN_Y_LOW, {8'($urandom_range(255)), screen_y_low});
        write_reg(REG_ADC_X_HIGH, adc_x_high);
        write_reg(REG_ADC_Y_HIGH, adc_y_high);
        write_reg(REG_SCREEN_X_HIGH, {8'($urandom_range(255)), screen_x_high});
        write_reg(REG_SCREEN_Y_HIGH, {8'($urandom_range(255)), screen_y_high});
        cfg_we <= 1'b0;
    endtask

    // Mostly a conversion command followed by the reads that shift its result out,
    // with the next command sometimes overlapping the last read; the rest is noise.
    task automatic random_exchange;
        logic [7:0] command;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            command = {1'b1, ($urandom_range(1) ? CH_X : CH_Y), 4'($urandom_range(15))};
        end
        else if (pick < 80)
        begin
            command = {1'b1, 3'($urandom_range(7)), 4'($urandom_range(15))};
        end
        else
        begin
            command = {1'b0, 7'($urandom_range(127))};
        end
        send_request(command, $urandom_range(9) < 8, 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        if (pick < 80)
        begin
            send_request({1'b0, 7'($urandom_range(127))}, 1'($urandom_range(1)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
            if ($urandom_range(1))
            begin
                send_request({1'b0, 7'($urandom_range(127))}, 1'($urandom_range(1)),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit hold_off);
        int  target;
        int  hold_at;
        bit  hold_done;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct <= stall_pct;
        target    = requests_sent + PHASE_ITEMS;
        hold_at   = requests_sent + 20;
        hold_done = !hold_off;
        while (requests_sent < target)
        begin
            if (!hold_done && requests_sent >= hold_at)
            begin
                hold_requests <= hold_requests + 1;
                hold_done = 1'b1;
            end
            random_exchange();
        end
        drain_replies();
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        req.valid          <= 1'b0;
        req.spi_byte_in    <= 8'h00;
        req.pen_down       <= 1'b0;
        req.touch_x        <= 8'h00;
        req.touch_y        <= 8'h00;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_ADC_X_LOW;
        cfg_data           <= 16'h0000;
        receiver_stall_pct <= 0;
        hold_requests      <= 0;
        requests_sent      = 0;
        sender_idle_pct    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset calibration.
        send_request(8'h00, 1'b0, 8'h00, 8'h00);
        send_request(8'hFF, 1'b1, 8'hFF, 8'hFF);
        send_request(8'h00, 1'b1, 8'h00, 8'h00);
        send_request(8'h00, 1'b0, 8'h00, 8'h00);
        for (int ch = 0; ch < 8; ch++)
        begin
            send_request({1'b1, 3'(ch), 4'h0}, 1'(ch % 2), (ch < 4) ? 8'h00 : 8'hFF,
                         (ch < 4) ? 8'hFF : 8'h00);
        end
        send_request({1'b1, CH_X, 4'h0}, 1'b1, 8'h00, 8'hFF);
        send_request(8'h00, 1'b0, 8'h00, 8'h00);
        send_request({1'b1, CH_Y, 4'hF}, 1'b1, 8'h00, 8'hFF);
        send_request(8'h7F, 1'b1, 8'hFF, 8'h00);
        send_request({1'b1, CH_X, 4'h5}, 1'b0, 8'hAA, 8'h55);
        send_request(8'h00, 1'b0, 8'h00, 8'h00);
        send_request({1'b1, CH_Y, 4'hA}, 1'b0, 8'h55, 8'hAA);
        send_request(8'h00, 1'b0, 8'h00, 8'h00);
        send_request(8'h00, 1'b0, 8'h00, 8'h00);
        drain_replies();

        // Widest span, so that the top of the screen saturates.
        load_calibration(16'd0, 16'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
        run_phase(0, 0, 1'b1);

        // Reversed axes give negative divisors and negative products.
        load_calibration(16'd4095, 16'hFFFF, 8'd255, 8'd200, 16'd0, 16'd0, 8'd0, 8'd20);
        run_phase(64, 0, 1'b0);

        // Equal screen points leave only the low ADC value.
        load_calibration(16'hFFFF, 16'd1234, 8'd128, 8'd0, 16'd0, 16'd4095, 8'd128, 8'd0);
        run_phase(0, 64, 1'b0);

        load_calibration(16'($urandom_range(65535)), 16'($urandom_range(4095)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         16'($urandom_range(4095)), 16'($urandom_range(65535)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
        run_phase(20, 20, 1'b1);

        load_calibration(16'd200, 16'd180, 8'd10, 8'd15, 16'd3900, 16'd3850, 8'd245, 8'd180);
        run_phase(0, 0, 1'b0);

        load_calibration(16'($urandom_range(8191)), 16'($urandom_range(8191)),
                         8'($urandom_range(63)), 8'($urandom_range(63)),
                         16'($urandom_range(8191)), 16'($urandom_range(8191)),
                         8'($urandom_range(192, 255)), 8'($urandom_range(192, 255)));
        run_phase(20, 20, 1'b0);

        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
